FILE: rtl/assert_macros.svh
// Assertion macros shared by the RTL of the bitmap range block.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked assertion, held off while reset is asserted.
`define ASSERT_CLK(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (prop)) else $error(msg);

// Clocked assertion, checked during reset as well.
`define ASSERT_ALWAYS(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

FILE: rtl/brst_pkg.sv
// Package with sizes, command codes and beat layout of the bitmap range block.
`timescale 1ns / 1ps
`default_nettype none
package brst_pkg;
	// map size in bits and word width (power of two)
	localparam int MAP_BITS   = 1024;
	localparam int WORD_BITS  = 32;
	localparam int WORD_COUNT = (MAP_BITS + WORD_BITS - 1) / WORD_BITS;
	localparam int POS_W      = $clog2(WORD_BITS);
	localparam int WIDX_W     = (WORD_COUNT > 1) ? $clog2(WORD_COUNT) : 1;
	localparam int SIZE_W     = 12;
	localparam int BIDX_W     = (POS_W + WIDX_W > SIZE_W) ? POS_W + WIDX_W : SIZE_W;

	localparam int CMD_W      = 2;
	localparam int START_W    = 10;
	localparam int COUNT_W    = 11;
	localparam int CFG_W      = 11;
	localparam int S_DATA_W   = 24;
	localparam int M_DATA_W   = 8;

	localparam logic [CFG_W-1:0] SIZE_RESET = 11'd1024;

	localparam logic [CMD_W-1:0] CMD_SET      = 2'd0;
	localparam logic [CMD_W-1:0] CMD_TEST_SET = 2'd1;
	localparam logic [CMD_W-1:0] CMD_TEST_CLR = 2'd2;

	typedef logic [WORD_BITS-1:0] word_t;
endpackage
`default_nettype wire

FILE: rtl/bitmap_range_set_and_test.sv
// Top level of the bitmap range set and test block.
// Usage:
//   The slave channel (s_tvalid/s_tready/s_tdata) takes one command beat:
//   cmd, start_bit and bit_count. The master channel returns one result beat
//   per command: range_ok and answer.
//   cfg_we/cfg_wdata write bits_in_use; write only while the block is idle.
//   A command walks the map one word per cycle over the words the range
//   covers, through one shared mask and compare unit. A beat is accepted
//   while idle; a rejected range or unused command goes straight to the
//   result, else the walk runs from the first to the last covered word, at
//   most WORD_COUNT = 32 words, then the result is presented.
//   A test stops at the first word that fails.
//   s_tready is high only while idle; the result holds on m_tdata until
//   m_tready takes it, and the next command is taken the cycle after.
//   Reset clears the map to zeros, sets bits_in_use to 1024 and empties
//   both channels.
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"
module bitmap_range_set_and_test
	import brst_pkg::*;
(
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire logic                cfg_we,
	input  wire logic [CFG_W-1:0]    cfg_wdata,
	input  wire logic                s_tvalid,
	output logic                     s_tready,
	// cmd [1:0], start_bit [11:2], bit_count [22:12], zero [23]
	input  wire logic [S_DATA_W-1:0] s_tdata,
	output logic                     m_tvalid,
	input  wire logic                m_tready,
	// range_ok [0], answer [1], zero [7:2]
	output logic [M_DATA_W-1:0]      m_tdata
);
	localparam logic [1:0] ST_IDLE = 2'd0;
	localparam logic [1:0] ST_WALK = 2'd1;
	localparam logic [1:0] ST_DONE = 2'd2;

	logic [1:0]        state_q;
	logic [CFG_W-1:0]  bits_in_use_q;
	logic [CMD_W-1:0]  cmd_q;
	logic              range_ok_q;
	logic              answer_q;
	logic [WIDX_W-1:0] w_q;
	logic [WIDX_W-1:0] wfirst_q;
	logic [WIDX_W-1:0] wlast_q;
	logic [POS_W-1:0]  lo_pos_q;
	logic [POS_W-1:0]  hi_pos_q;
	word_t             words_q [WORD_COUNT];

	logic [CMD_W-1:0]   in_cmd;
	logic [START_W-1:0] in_start;
	logic [COUNT_W-1:0] in_count;
	logic [SIZE_W-1:0]  size_c;
	logic               ok_c;
	logic [BIDX_W-1:0]  start_ext;
	logic [BIDX_W-1:0]  end_c;
	logic               accept;
	logic               walk_c;

	word_t             word_c;
	word_t             mask_c;
	word_t             lo_mask;
	word_t             hi_mask;
	logic              pass_c;
	logic              last_c;

	assign in_cmd   = s_tdata[1:0];
	assign in_start = s_tdata[11:2];
	assign in_count = s_tdata[22:12];
	assign accept   = s_tvalid && s_tready;

	always_comb begin
		if (32'(bits_in_use_q) > 32'(MAP_BITS)) begin
			size_c = SIZE_W'(MAP_BITS);
		end else begin
			size_c = SIZE_W'(bits_in_use_q);
		end
		ok_c = (in_count != '0) && (SIZE_W'(in_start) < size_c) &&
			(SIZE_W'(in_count) <= size_c - SIZE_W'(in_start));
		start_ext = BIDX_W'(in_start);
		end_c     = start_ext + BIDX_W'(in_count) - BIDX_W'(1);
		walk_c    = ok_c && (in_cmd == CMD_SET || in_cmd == CMD_TEST_SET ||
			in_cmd == CMD_TEST_CLR);
	end

	// shared mask and compare unit, one word per cycle
	always_comb begin
		word_c  = words_q[w_q];
		lo_mask = {WORD_BITS{1'b1}} << ((w_q == wfirst_q) ? lo_pos_q : '0);
		hi_mask = {WORD_BITS{1'b1}} >> ((w_q == wlast_q) ? ~hi_pos_q : '0);
		mask_c  = lo_mask & hi_mask;
		if (cmd_q == CMD_TEST_SET) begin
			pass_c = (word_c & mask_c) == mask_c;
		end else begin
			pass_c = (word_c & mask_c) == '0;
		end
		last_c = (w_q == wlast_q);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bits_in_use_q <= SIZE_RESET;
		end else if (cfg_we) begin
			bits_in_use_q <= cfg_wdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_IDLE;
			range_ok_q <= 1'b0;
			answer_q   <= 1'b0;
			for (int i = 0; i < WORD_COUNT; i++) begin
				words_q[i] <= '0;
			end
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (accept) begin
						range_ok_q <= ok_c;
						answer_q   <= walk_c && (in_cmd != CMD_SET);
						state_q    <= walk_c ? ST_WALK : ST_DONE;
					end
				end
				ST_WALK: begin
					if (cmd_q == CMD_SET) begin
						words_q[w_q] <= word_c | mask_c;
					end else if (!pass_c) begin
						answer_q <= 1'b0;
					end
					if (last_c || (cmd_q != CMD_SET && !pass_c)) begin
						state_q <= ST_DONE;
					end
				end
				ST_DONE: begin
					if (m_tready) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			cmd_q    <= in_cmd;
			w_q      <= start_ext[POS_W +: WIDX_W];
			wfirst_q <= start_ext[POS_W +: WIDX_W];
			wlast_q  <= end_c[POS_W +: WIDX_W];
			lo_pos_q <= start_ext[POS_W-1:0];
			hi_pos_q <= end_c[POS_W-1:0];
		end else if (state_q == ST_WALK) begin
			w_q <= w_q + WIDX_W'(1);
		end
	end

	assign s_tready = (state_q == ST_IDLE);
	assign m_tvalid = (state_q == ST_DONE);
	assign m_tdata  = {{(M_DATA_W-2){1'b0}}, answer_q, range_ok_q};

	`ASSERT_CLK(a_one_side, !(s_tready && m_tvalid), "ready while a result is pending")
	`ASSERT_CLK(a_walk_bound, (state_q == ST_WALK) |-> (w_q <= wlast_q), "walk past last word")
	`ASSERT_CLK(a_reject_fast, (accept && !ok_c) |=> (m_tvalid && !m_tdata[0] && !m_tdata[1]),
		"rejected range not answered at once")
	`ASSERT_CLK(a_set_no_answer, (m_tvalid && cmd_q == CMD_SET) |-> !m_tdata[1],
		"set command reports an answer")
endmodule
`default_nettype wire
